/* src/spf_pkg.sv */
`timescale 1ns / 1ps

package spf_pkg;

	// Width of query values and of factors on the result side.
	localparam int VAL_W = 16;

	// Result status codes.
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_NONE  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_PSTART,
		S_MARK,
		S_IDLE,
		S_CHECK,
		S_LOOK,
		S_DIV
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       clear;       // clearing pass: write zero, step the address by one
		logic       wr;          // write the table at the sweep address
		logic       m_init;      // start the multiples at p squared
		logic       m_step;      // advance the sweep address
		logic       p_next;      // move on to the next smaller candidate p
		logic       n_load;      // capture a new query word
		logic       rd;          // read the table at the current value
		logic       emit;        // load the output register
		logic [1:0] emit_status; // status of the word being emitted
		logic       div_start;   // begin dividing the value by the table entry
		logic       div_step;    // one quotient bit
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic m_end;     // next sweep address would pass the top of the table
		logic p_last;    // the candidate p is two
		logic is_range;  // current value is above the limit or above MAX_VALUE
		logic is_small;  // current value is zero or one
		logic is_prime;  // table entry read back is zero
		logic out_free;  // output register can take a word this cycle
		logic div_last;  // the divider is on its final bit
	} sts_t;

	// Integer square root, evaluated at elaboration time only.
	function automatic int isqrt(input int v);
		int r;
		int b;
		int t;
		r = 0;
		for (b = 10; b >= 0; b--) begin
			t = r + (1 << b);
			if (t * t <= v) begin
				r = t;
			end
		end
		return r;
	endfunction

endpackage

/* src/spf_ram.sv */
`timescale 1ns / 1ps

module spf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

/* src/spf_ctrl.sv */
`timescale 1ns / 1ps

module spf_ctrl import spf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.m_end) begin
					state_d = S_PSTART;
				end
			end
			S_PSTART: begin
				state_d = S_MARK;
			end
			S_MARK: begin
				if (sts.m_end) begin
					state_d = sts.p_last ? S_IDLE : S_PSTART;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_CHECK;
				end
			end
			S_CHECK: begin
				if (sts.is_range || sts.is_small) begin
					if (sts.out_free) begin
						state_d = S_IDLE;
					end
				end else begin
					state_d = S_LOOK;
				end
			end
			S_LOOK: begin
				if (sts.out_free) begin
					state_d = sts.is_prime ? S_IDLE : S_DIV;
				end
			end
			S_DIV: begin
				if (sts.div_last) begin
					state_d = S_CHECK;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear  = 1'b1;
				cmd.wr     = 1'b1;
				cmd.m_step = 1'b1;
			end
			S_PSTART: begin
				cmd.m_init = 1'b1;
			end
			S_MARK: begin
				cmd.wr     = 1'b1;
				cmd.m_step = 1'b1;
				cmd.p_next = sts.m_end && !sts.p_last;
			end
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.n_load = in_valid;
			end
			S_CHECK: begin
				if (sts.is_range || sts.is_small) begin
					cmd.emit        = sts.out_free;
					cmd.emit_status = sts.is_range ? ST_RANGE : ST_NONE;
				end else begin
					cmd.rd = 1'b1;
				end
			end
			S_LOOK: begin
				cmd.emit        = sts.out_free;
				cmd.emit_status = ST_OK;
				cmd.div_start   = sts.out_free && !sts.is_prime;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

/* src/spf_dp.sv */
`timescale 1ns / 1ps

module spf_dp import spf_pkg::*; #(
	parameter int MAX_VALUE = 65535
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_t             cmd,
	output sts_t             sts,
	input  logic [VAL_W-1:0] value,
	input  logic             cfg_we,
	input  logic [VAL_W-1:0] cfg_wdata,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] factor,
	output logic [1:0]       status,
	output logic             last
);

	localparam int DEPTH = MAX_VALUE + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int MW    = AW + 1;
	localparam int PMAX  = isqrt(MAX_VALUE);
	localparam int FW    = $clog2(PMAX + 1);
	localparam int CW    = $clog2(VAL_W);

	logic [VAL_W-1:0] limit_q;
	logic [MW-1:0]    m_q;
	logic [FW-1:0]    p_q;
	logic [VAL_W-1:0] n_q;
	logic [FW-1:0]    f_q;
	logic [FW-1:0]    rem_q;
	logic [VAL_W-1:0] quo_q;
	logic [CW-1:0]    cnt_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] factor_q;
	logic [1:0]       status_q;
	logic             last_q;

	logic [FW-1:0]    rdata;
	logic [FW-1:0]    wdata;
	logic [MW-1:0]    m_inc;
	logic [MW-1:0]    m_plus;
	logic [2*FW-1:0]  p_sq;
	logic [FW:0]      trial;
	logic [FW:0]      diff;
	logic             ge;
	logic [FW-1:0]    rem_next;
	logic [VAL_W-1:0] quo_next;
	logic             prime_f;

	spf_ram #(
		.WIDTH(FW),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(m_q[AW-1:0]),
		.wdata(wdata),
		.re   (cmd.rd),
		.raddr(AW'(n_q)),
		.rdata(rdata)
	);

	// Sweep address: step by one while clearing, by p while marking multiples.
	assign wdata  = cmd.clear ? '0 : p_q;
	assign m_inc  = cmd.clear ? MW'(1) : MW'(p_q);
	assign m_plus = m_q + m_inc;
	assign p_sq   = p_q * p_q;

	// One restoring division step: one quotient bit a cycle.
	assign trial    = {rem_q, quo_q[VAL_W-1]};
	assign diff     = trial - {1'b0, f_q};
	assign ge       = trial >= {1'b0, f_q};
	assign rem_next = ge ? diff[FW-1:0] : trial[FW-1:0];
	assign quo_next = {quo_q[VAL_W-2:0], ge};

	assign prime_f = (rdata == '0);

	always_comb begin
		sts.m_end    = m_plus > MW'(MAX_VALUE);
		sts.p_last   = (p_q == FW'(2));
		sts.is_range = (n_q > limit_q) || (32'(n_q) > 32'(MAX_VALUE));
		sts.is_small = (n_q[VAL_W-1:1] == '0);
		sts.is_prime = prime_f;
		sts.out_free = !out_valid_q || out_ready;
		sts.div_last = (cnt_q == CW'(VAL_W - 1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q     <= '1;
			m_q         <= '0;
			p_q         <= FW'(PMAX);
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.m_init) begin
				m_q <= MW'(p_sq);
			end else if (cmd.m_step) begin
				m_q <= m_plus;
			end
			if (cmd.p_next) begin
				p_q <= p_q - FW'(1);
			end
			if (cmd.div_start) begin
				cnt_q <= '0;
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.n_load) begin
			n_q <= value;
		end else if (cmd.div_step && sts.div_last) begin
			n_q <= quo_next;
		end
		if (cmd.div_start) begin
			f_q   <= rdata;
			rem_q <= '0;
			quo_q <= n_q;
		end else if (cmd.div_step) begin
			rem_q <= rem_next;
			quo_q <= quo_next;
		end
		if (cmd.emit) begin
			status_q <= cmd.emit_status;
			if (cmd.emit_status == ST_OK) begin
				factor_q <= prime_f ? n_q : VAL_W'(rdata);
				last_q   <= prime_f;
			end else begin
				factor_q <= '0;
				last_q   <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign factor    = factor_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

/* src/spf_sieve_factorizer_unit.sv */
`timescale 1ns / 1ps
// Smallest-prime-factor sieve and factorizer.
// Input channel: in_valid/in_ready with the word value. Output channel: out_valid/out_ready
// with the word factor, status and last. Each query gives its prime factors in
// nondecreasing order, with multiplicity; the final word of a query has last set.
// A value of zero or one gives a single word with status 1 unless it is out of range,
// and a value above the query_limit register (or above MAX_VALUE) a single word with
// status 2; factor is zero in both. query_limit is written through cfg_we/cfg_wdata;
// the user must write it only while the block is idle, as the block does not enforce it.
// After reset the table is built first and in_ready stays low meanwhile: a clearing
// pass over all MAX_VALUE+1 entries, then a sieve that takes p from the square root of
// MAX_VALUE down to 2 and writes p to every multiple from p squared upwards, one table
// write a cycle. One query is handled at a time. A special word is emitted from the
// check state entered on acceptance, the first factor word from the look state after
// the table read. Each composite step is a table read, the emission of the factor and
// a restoring divider that takes one quotient bit a cycle; the final prime factor needs
// only the read and its word, after which the controller returns to idle. The output
// register holds a word until it is taken; while the receiver stalls the controller
// waits before emitting the next word, so nothing is dropped.

module spf_sieve_factorizer_unit import spf_pkg::*; #(
	parameter int MAX_VALUE = 65535
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [VAL_W-1:0] value,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [VAL_W-1:0] factor,
	output logic [1:0]       status,
	output logic             last,
	input  logic             cfg_we,
	input  logic [VAL_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	// The controller sequences the clearing pass, the sieve and each query.
	spf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sts     (sts),
		.cmd     (cmd)
	);

	// The datapath holds the table memory, the sweep counters, the divider,
	// the limit register and the output register.
	spf_dp #(
		.MAX_VALUE(MAX_VALUE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.value    (value),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.factor   (factor),
		.status   (status),
		.last     (last)
	);

endmodule

/* verif/spf_factor_checker.sv */
`timescale 1ns / 1ps

module spf_factor_checker import spf_pkg::*; #(
	parameter int MAX_VALUE = 65535
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [VAL_W-1:0] value,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [VAL_W-1:0] factor,
	input  logic [1:0]       status,
	input  logic             last,
	input  logic             cfg_we,
	input  logic [VAL_W-1:0] cfg_wdata,
	output int               errors,
	output int               pending
);

	localparam int RESULT_CAP = 16;

	typedef struct packed {
		logic [VAL_W-1:0] factor;
		logic [1:0]       status;
		logic             last;
	} factor_word_t;

	factor_word_t     factor_words_due[$];
	factor_word_t     got_word;
	factor_word_t     due_word;
	logic [VAL_W-1:0] limit_copy;
	int               fail_count;

	function automatic int smallest_factor(input int n);
		int d;
		for (d = 2; d * d <= n; d++) begin
			if (n % d == 0) begin
				return d;
			end
		end
		return n;
	endfunction

	// Appends one expected word at the tail of the queue.
	function automatic void queue_word(input factor_word_t w);
		factor_words_due.insert(factor_words_due.size(), w);
	endfunction

	// Queues every word that one accepted query value must produce.
	function automatic void push_factorization(input logic [VAL_W-1:0] v);
		int           n;
		int           f;
		int           k;
		factor_word_t w;
		n = int'(v);
		k = 0;
		if (n > int'(limit_copy) || n > MAX_VALUE) begin
			w = '{factor: '0, status: ST_RANGE, last: 1'b1};
			queue_word(w);
		end else if (n < 2) begin
			w = '{factor: '0, status: ST_NONE, last: 1'b1};
			queue_word(w);
		end else begin
			while (n > 1 && k < RESULT_CAP) begin
				f = smallest_factor(n);
				n = n / f;
				w.factor = f[VAL_W-1:0];
				w.status = ST_OK;
				w.last   = (n <= 1 || k == RESULT_CAP - 1);
				queue_word(w);
				k++;
			end
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_copy = 16'hFFFF;
			factor_words_due.delete();
			fail_count = 0;
			errors  <= 0;
			pending <= 0;
		end else begin
			if (cfg_we) begin
				limit_copy = cfg_wdata;
			end
			// Output words are matched before new expectations are queued.
			if (out_valid && out_ready) begin
				got_word.factor = factor;
				got_word.status = status;
				got_word.last   = last;
				if (factor_words_due.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) begin
						$display("spf checker: unexpected word factor %0d status %0d last %0d",
							factor, status, last);
					end
				end else begin
					due_word = factor_words_due.pop_front();
					if (got_word.factor !== due_word.factor || got_word.status !== due_word.status
						|| got_word.last !== due_word.last) begin
						fail_count++;
						if (fail_count <= 10) begin
							$display("spf checker: expected %0d/%0d/%0d, got %0d/%0d/%0d",
								due_word.factor, due_word.status, due_word.last,
								factor, status, last);
						end
					end
				end
			end
			if (in_valid && in_ready) begin
				push_factorization(value);
			end
			errors  <= fail_count;
			pending <= factor_words_due.size();
		end
	end

endmodule

/* verif/tb_spf_sieve_factorizer_unit.sv */
`timescale 1ns / 1ps

module tb_spf_sieve_factorizer_unit;
	import spf_pkg::*;

	localparam int MAX_VALUE = 65535;
	// The longest stretch without any accepted word is the table build after reset:
	// a clearing pass and the sieve. STALL_LIMIT is set above its length.
	localparam int STALL_LIMIT = 1500000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [VAL_W-1:0] value = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [VAL_W-1:0] factor;
	logic [1:0]       status;
	logic             last;
	logic             cfg_we = 1'b0;
	logic [VAL_W-1:0] cfg_wdata = '0;

	int errors;
	int pending;
	int quiet_cycles = 0;
	int stall_left = 0;
	bit quiet_phase = 1'b0;
	int current_limit = 65535;

	spf_sieve_factorizer_unit #(
		.MAX_VALUE(MAX_VALUE)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.factor   (factor),
		.status   (status),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	spf_factor_checker #(
		.MAX_VALUE(MAX_VALUE)
	) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.value    (value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.factor   (factor),
		.status   (status),
		.last     (last),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// The receiver stalls in random bursts, and never in the final phase.
	always @(posedge clk) begin
		if (quiet_phase) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left = stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready <= 1'b0;
			stall_left = $urandom_range(0, 18);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Watchdog: any accepted word on either channel restarts the count.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb_spf_sieve_factorizer_unit: errors");
			$finish;
		end
	end

	// Offers one query word and returns at the edge where it is accepted. Valid is left
	// high so that a following word can be presented without a gap; an optional idle
	// burst in front lowers it first.
	task automatic send_query(input int v);
		int gap;
		if (!quiet_phase && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 19);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value    <= v[VAL_W-1:0];
		do begin
			@(posedge clk);
		end while (!in_ready);
	endtask

	// Stops offering words and waits until every predicted word has been taken and
	// the block is back at rest with in_ready high.
	task automatic wait_all_factors_out();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
		while (!in_ready) begin
			@(posedge clk);
		end
	endtask

	// The limit register is only written once the block has gone idle.
	task automatic write_query_limit(input int lim);
		wait_all_factors_out();
		cfg_we    <= 1'b1;
		cfg_wdata <= lim[VAL_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		current_limit = lim;
	endtask

	// Mixes values that stress different parts of the factorizer: tiny values,
	// out-of-range values, powers of two (the longest factor runs), values right at
	// the limit, smooth numbers with many small factors, and plain random words.
	function automatic int pick_query_value(input int lim);
		int smooth;
		int p;
		int tries;
		int small_primes[4];
		small_primes = '{2, 3, 5, 7};
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 15);
			1: begin
				if (lim < 65535) begin
					return $urandom_range(lim + 1, 65535);
				end
				return $urandom_range(0, 65535);
			end
			2: return 1 << $urandom_range(0, 15);
			3: return lim - $urandom_range(0, 2);
			4, 5: begin
				smooth = 1;
				for (tries = 0; tries < 20; tries++) begin
					p = small_primes[$urandom_range(0, 3)];
					if (smooth * p <= lim) begin
						smooth = smooth * p;
					end
				end
				return smooth;
			end
			default: return $urandom_range(0, 65535);
		endcase
	endfunction

	int at_full_range[14];
	int at_lowest_limit[5];
	int at_mid_limit[3];
	int i;

	initial begin
		// Zero and one, the smallest prime and square, the largest value (which sits
		// exactly at the reset limit), the largest prime, the longest factor run, a
		// square of a large prime, a square with three repeated primes and a primorial.
		at_full_range   = '{0, 1, 2, 3, 4, 65535, 65534, 65521, 32768, 63001, 49, 30030,
			65025, 6};
		// With the lowest limit only two is in range; zero and one still count as
		// having no factors.
		at_lowest_limit = '{2, 3, 1, 0, 65535};
		at_mid_limit    = '{1000, 1001, 999};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. The first word waits for the table build to finish.
		foreach (at_full_range[k]) begin
			send_query(at_full_range[k]);
		end
		write_query_limit(2);
		foreach (at_lowest_limit[k]) begin
			send_query(at_lowest_limit[k]);
		end
		write_query_limit(1000);
		foreach (at_mid_limit[k]) begin
			send_query(at_mid_limit[k]);
		end

		// Random part, across several limit settings.
		write_query_limit(65535);
		for (i = 0; i < 70; i++) begin
			send_query(pick_query_value(current_limit));
		end

		write_query_limit($urandom_range(256, 65534));
		for (i = 0; i < 70; i++) begin
			// Part way through, the sender holds off until everything has drained.
			if (i == 35) begin
				wait_all_factors_out();
			end
			send_query(pick_query_value(current_limit));
		end

		write_query_limit(2);
		for (i = 0; i < 30; i++) begin
			send_query(pick_query_value(current_limit));
		end

		// Final phase at full range, with neither side idling.
		write_query_limit(65535);
		quiet_phase = 1'b1;
		for (i = 0; i < 80; i++) begin
			send_query(pick_query_value(current_limit));
		end

		wait_all_factors_out();
		repeat (20) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("tb_spf_sieve_factorizer_unit: clean");
		end else begin
			$display("tb_spf_sieve_factorizer_unit: errors");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/spf_pkg.sv
src/spf_ram.sv
src/spf_ctrl.sv
src/spf_dp.sv
src/spf_sieve_factorizer_unit.sv
verif/spf_factor_checker.sv
verif/tb_spf_sieve_factorizer_unit.sv
